>>> sv/dobd_pkg.sv
// Shared types and constants for the detector output box decoder.
// Used by the front end, the record queue, the back end and the top level.
`timescale 1ns / 1ps
`default_nettype none

package dobd_pkg;

  // Largest number of class scores in one record.
  localparam int unsigned MAX_CLASSES = 80;
  // Depth of the record queue between front and back end.
  localparam int unsigned QUEUE_DEPTH = 2;
  // Scales below 0.1 in Q8.16 select percent/normalized mode.
  localparam logic [23:0] SCALE_PCT_LIMIT = 24'd6554;
  // Score multiplier in percent mode.
  localparam logic [10:0] PCT_FACTOR = 11'd100;
  // Rounding offset of one half in Q.16.
  localparam logic signed [45:0] HALF_Q16 = 46'sd32768;

  // Configuration register indexes.
  localparam logic [2:0] CFG_NUM_CLASSES   = 3'd0;
  localparam logic [2:0] CFG_ZERO_OFFSET   = 3'd1;
  localparam logic [2:0] CFG_DEQUANT_SCALE = 3'd2;
  localparam logic [2:0] CFG_MIN_SCORE     = 3'd3;
  localparam logic [2:0] CFG_MODEL_SIDE    = 3'd4;
  localparam logic [2:0] CFG_WIDTH_SCALE   = 3'd5;
  localparam logic [2:0] CFG_HEIGHT_SCALE  = 3'd6;

  // Element positions that carry the raw box values.
  localparam logic [6:0] POS_X     = 7'd0;
  localparam logic [6:0] POS_Y     = 7'd1;
  localparam logic [6:0] POS_W     = 7'd2;
  localparam logic [6:0] POS_H     = 7'd3;
  localparam logic [6:0] POS_CLASS = 7'd4;

  // Back end sequencer: operands issued on steps 0 to 4, done on step 7.
  localparam logic [2:0] LAST_STEP = 3'd7;

  typedef enum logic [2:0] {
    TAG_SCORE = 3'd0,
    TAG_X     = 3'd1,
    TAG_Y     = 3'd2,
    TAG_W     = 3'd3,
    TAG_H     = 3'd4
  } tag_e;

  typedef enum logic {
    BK_IDLE = 1'b0,
    BK_RUN  = 1'b1
  } bk_state_e;

  typedef struct packed {
    logic [6:0]        num_classes;
    logic signed [7:0] zero_offset;
    logic [23:0]       dequant_scale;
    logic [7:0]        min_score;
    logic [10:0]       model_side;
    logic [23:0]       width_scale;
    logic [23:0]       height_scale;
  } cfg_t;

  // One finished record handed from the front end to the back end.
  typedef struct packed {
    logic signed [7:0] raw_x;
    logic signed [7:0] raw_y;
    logic signed [7:0] raw_w;
    logic signed [7:0] raw_h;
    logic signed [7:0] best_value;
    logic [6:0]        best_class;
  } rec_t;

endpackage

`default_nettype wire

>>> sv/dobd_front.sv
// Front end: takes one element per request, keeps the raw box and the running argmax.
// Depends on dobd_pkg for the configuration and record types.
`timescale 1ns / 1ps
`default_nettype none

module dobd_front (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire dobd_pkg::cfg_t     cfg_i,
  input  wire logic               accept_i,
  input  wire logic signed [7:0]  element_value_i,
  output dobd_pkg::rec_t          rec_o,
  output logic                    push_o
);

  logic [6:0]        pos_q, pos_d;
  logic signed [7:0] best_q, best_d;
  logic [6:0]        cls_q, cls_d;
  logic signed [7:0] raw_x_q, raw_y_q, raw_w_q, raw_h_q;
  logic [6:0]        n_cls;
  logic [6:0]        t_idx;
  logic signed [7:0] cur_best;
  logic [6:0]        cur_cls;
  logic              last_cls;
  logic              is_class;

  // Clamp the class count to the supported range.
  always_comb begin
    if (cfg_i.num_classes == 7'd0) begin
      n_cls = 7'd1;
    end else if (cfg_i.num_classes > 7'(dobd_pkg::MAX_CLASSES)) begin
      n_cls = 7'(dobd_pkg::MAX_CLASSES);
    end else begin
      n_cls = cfg_i.num_classes;
    end
  end

  // Running argmax; the first class of a record starts from the minimum.
  always_comb begin
    is_class = (pos_q >= dobd_pkg::POS_CLASS);
    t_idx    = pos_q - dobd_pkg::POS_CLASS;
    cur_best = (t_idx == 7'd0) ? -8'sd128 : best_q;
    cur_cls  = (t_idx == 7'd0) ? 7'd0 : cls_q;
    if (element_value_i > cur_best) begin
      best_d = element_value_i;
      cls_d  = t_idx;
    end else begin
      best_d = cur_best;
      cls_d  = cur_cls;
    end
    last_cls = is_class && (({1'b0, t_idx} + 8'd1) >= {1'b0, n_cls});
  end

  // Position counter wraps to the start of a record after the last class.
  always_comb begin
    if (last_cls) begin
      pos_d = dobd_pkg::POS_X;
    end else begin
      pos_d = pos_q + 7'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= dobd_pkg::POS_X;
      best_q  <= -8'sd128;
      cls_q   <= 7'd0;
      raw_x_q <= 8'sd0;
      raw_y_q <= 8'sd0;
      raw_w_q <= 8'sd0;
      raw_h_q <= 8'sd0;
    end else if (accept_i) begin
      pos_q <= pos_d;
      case (pos_q)
        dobd_pkg::POS_X: raw_x_q <= element_value_i;
        dobd_pkg::POS_Y: raw_y_q <= element_value_i;
        dobd_pkg::POS_W: raw_w_q <= element_value_i;
        dobd_pkg::POS_H: raw_h_q <= element_value_i;
        default: begin
          best_q <= best_d;
          cls_q  <= cls_d;
        end
      endcase
    end
  end

  // A completed record goes to the queue on its last class element.
  always_comb begin
    push_o           = accept_i && last_cls;
    rec_o.raw_x      = raw_x_q;
    rec_o.raw_y      = raw_y_q;
    rec_o.raw_w      = raw_w_q;
    rec_o.raw_h      = raw_h_q;
    rec_o.best_value = best_d;
    rec_o.best_class = cls_d;
  end

endmodule

`default_nettype wire

>>> sv/dobd_queue.sv
// Short record queue between the front end and the back end.
// Depends on dobd_pkg for the record type.
`timescale 1ns / 1ps
`default_nettype none

module dobd_queue #(
  parameter int unsigned Depth = dobd_pkg::QUEUE_DEPTH
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_i,
  input  wire dobd_pkg::rec_t push_data_i,
  input  wire logic           pop_i,
  output logic                full_o,
  output logic                valid_o,
  output dobd_pkg::rec_t      data_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  dobd_pkg::rec_t  mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            do_push, do_pop;

  // Pointer and fill count updates.
  always_comb begin
    do_push  = push_i && !full_o;
    do_pop   = pop_i && valid_o;
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    count_d = count_q + CntW'(do_push) - CntW'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  assign full_o  = (count_q == CntW'(Depth));
  assign valid_o = (count_q != '0);
  assign data_o  = mem_q[rd_ptr_q];

endmodule

`default_nettype wire

>>> sv/dobd_back.sv
// Back end: dequantizes the best score and the four box values of one record
// through a three-multiplier pipeline and holds the result. Depends on dobd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dobd_back (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire dobd_pkg::cfg_t cfg_i,
  input  wire logic           rec_valid_i,
  input  wire dobd_pkg::rec_t rec_i,
  output logic                rec_pop_o,
  output logic                out_valid_o,
  input  wire logic           out_ready_i,
  output logic [15:0]         box_x_o,
  output logic [15:0]         box_y_o,
  output logic [15:0]         box_w_o,
  output logic [15:0]         box_h_o,
  output logic [7:0]          score_o,
  output logic [6:0]          class_index_o
);

  dobd_pkg::bk_state_e state_q, state_d;
  logic [2:0]          step_q, step_d;
  logic                issue;
  logic                finish;
  logic                rescale;

  // Pipeline stages.
  logic                v1_q, v2_q, v3_q;
  dobd_pkg::tag_e      t0, t1_q, t2_q, t3_q;
  logic signed [7:0]   raw0;
  logic signed [8:0]   diff0;
  logic signed [33:0]  p1_d, p1_q;
  logic [10:0]         fac1;
  logic signed [45:0]  p2_d, p2_q;
  logic [26:0]         hi2;
  logic [26:0]         clip2;
  logic [23:0]         img2;
  logic [50:0]         p3_d, p3_q;
  logic [18:0]         res3;
  logic [15:0]         sat3;

  // Score decision.
  logic signed [45:0]  thr_q16;
  logic signed [45:0]  rnd2;
  logic [29:0]         rs2;
  logic                emit_q;

  // Result registers.
  logic                out_valid_q, out_valid_d;
  logic [15:0]         box_x_q, box_y_q, box_w_q, box_h_q;
  logic [7:0]          score_q;
  logic [6:0]          class_q;

  // Sequencer next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      dobd_pkg::BK_IDLE: begin
        if (rec_valid_i && !out_valid_q) begin
          state_d = dobd_pkg::BK_RUN;
        end
      end
      dobd_pkg::BK_RUN: begin
        if (step_q == dobd_pkg::LAST_STEP) begin
          state_d = dobd_pkg::BK_IDLE;
        end
      end
      default: state_d = dobd_pkg::BK_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    issue     = (state_q == dobd_pkg::BK_RUN) && (step_q <= 3'(dobd_pkg::TAG_H));
    finish    = (state_q == dobd_pkg::BK_RUN) && (step_q == dobd_pkg::LAST_STEP);
    rec_pop_o = finish;
    step_d    = (state_q == dobd_pkg::BK_RUN) ? step_q + 3'd1 : 3'd0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= dobd_pkg::BK_IDLE;
      step_q  <= 3'd0;
      v1_q    <= 1'b0;
      v2_q    <= 1'b0;
      v3_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      v1_q    <= issue;
      v2_q    <= v1_q;
      v3_q    <= v2_q;
    end
  end

  assign rescale = (cfg_i.dequant_scale < dobd_pkg::SCALE_PCT_LIMIT);

  // Stage 1: pick the operand and multiply by the dequantization scale.
  always_comb begin
    t0 = dobd_pkg::tag_e'(step_q);
    case (t0)
      dobd_pkg::TAG_SCORE: raw0 = rec_i.best_value;
      dobd_pkg::TAG_X:     raw0 = rec_i.raw_x;
      dobd_pkg::TAG_Y:     raw0 = rec_i.raw_y;
      dobd_pkg::TAG_W:     raw0 = rec_i.raw_w;
      dobd_pkg::TAG_H:     raw0 = rec_i.raw_h;
      default:             raw0 = 8'sd0;
    endcase
    diff0 = 9'(raw0) - 9'(cfg_i.zero_offset);
    p1_d  = 34'(diff0) * 34'($signed({1'b0, cfg_i.dequant_scale}));
  end

  // Stage 2: percent mode scales the score by 100 and boxes by the model side.
  always_comb begin
    if (!rescale) begin
      fac1 = 11'd1;
    end else if (t1_q == dobd_pkg::TAG_SCORE) begin
      fac1 = dobd_pkg::PCT_FACTOR;
    end else begin
      fac1 = cfg_i.model_side;
    end
    p2_d = 46'(p1_q) * 46'($signed({1'b0, fac1}));
  end

  // Stage 3: clip the box value to the model side and apply the image scale.
  always_comb begin
    hi2 = {cfg_i.model_side, 16'd0};
    if (p2_q < 46'sd0) begin
      clip2 = '0;
    end else if (p2_q > $signed(46'(hi2))) begin
      clip2 = hi2;
    end else begin
      clip2 = p2_q[26:0];
    end
    if (t2_q == dobd_pkg::TAG_Y || t2_q == dobd_pkg::TAG_H) begin
      img2 = cfg_i.height_scale;
    end else begin
      img2 = cfg_i.width_scale;
    end
    p3_d = 51'(clip2) * 51'(img2);
  end

  // Score threshold compare and rounding, taken from the stage 2 product.
  always_comb begin
    thr_q16 = $signed(46'({cfg_i.min_score, 16'd0}));
    rnd2    = p2_q + dobd_pkg::HALF_Q16;
    rs2     = rnd2[45:16];
  end

  // Stage 4: drop the Q.32 fraction and saturate.
  always_comb begin
    res3 = p3_q[50:32];
    sat3 = (|res3[18:16]) ? 16'hFFFF : res3[15:0];
  end

  always_ff @(posedge clk_i) begin
    p1_q <= p1_d;
    t1_q <= t0;
    p2_q <= p2_d;
    t2_q <= t1_q;
    p3_q <= p3_d;
    t3_q <= t2_q;
  end

  // Collect results as they leave the pipeline.
  always_ff @(posedge clk_i) begin
    if (v2_q && t2_q == dobd_pkg::TAG_SCORE) begin
      emit_q  <= (p2_q > thr_q16);
      score_q <= (|rs2[29:8]) ? 8'hFF : rs2[7:0];
    end
    if (v3_q) begin
      case (t3_q)
        dobd_pkg::TAG_X: box_x_q <= sat3;
        dobd_pkg::TAG_Y: box_y_q <= sat3;
        dobd_pkg::TAG_W: box_w_q <= sat3;
        dobd_pkg::TAG_H: box_h_q <= sat3;
        default: ;
      endcase
    end
    if (finish) begin
      class_q <= rec_i.best_class;
    end
  end

  // Output valid: raised when a record passes the threshold, dropped when taken.
  always_comb begin
    out_valid_d = out_valid_q;
    if (finish) begin
      out_valid_d = emit_q;
    end else if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign box_x_o       = box_x_q;
  assign box_y_o       = box_y_q;
  assign box_w_o       = box_w_q;
  assign box_h_o       = box_h_q;
  assign score_o       = score_q;
  assign class_index_o = class_q;

endmodule

`default_nettype wire

>>> sv/detector_output_box_decode_top.sv
// Detector output box decoder.
// Channels: the input takes one int8 element per request (x, y, w, h, then
// num_classes class scores). The output gives one box request per record
// whose score is above the threshold; other records give nothing.
// The front end takes one element every cycle while the queue has room,
// and hands each finished record to a two-entry queue. The back end runs
// one record at a time through a three-stage multiplier pipeline, one
// operand per cycle, and starts the next record only when it is done with
// the last one and any result it gave has been taken; records have at least
// 5 elements, so the front end stalls (in_ready_o low) only when the queue
// is full.
// A result waits in the output register while out_ready_i is low; the
// front end keeps taking elements until the queue fills.
// Reset clears the record position, the argmax, the queue and the output
// valid, and loads the configuration registers with their defaults.
// Depends on dobd_pkg, dobd_front, dobd_queue and dobd_back.
`timescale 1ns / 1ps
`default_nettype none

module detector_output_box_decode_top #(
  parameter int unsigned QueueDepth = dobd_pkg::QUEUE_DEPTH
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_we_i,
  input  wire logic [2:0]        cfg_index_i,
  input  wire logic [23:0]       cfg_data_i,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire logic signed [7:0] element_value_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output logic [15:0]            box_x_o,
  output logic [15:0]            box_y_o,
  output logic [15:0]            box_w_o,
  output logic [15:0]            box_h_o,
  output logic [7:0]             score_o,
  output logic [6:0]             class_index_o
);

  dobd_pkg::cfg_t cfg_q;
  dobd_pkg::rec_t push_rec;
  dobd_pkg::rec_t head_rec;
  logic           push;
  logic           pop;
  logic           q_full;
  logic           q_valid;
  logic           accept;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.num_classes   <= 7'd80;
      cfg_q.zero_offset   <= 8'sd0;
      cfg_q.dequant_scale <= 24'd256;
      cfg_q.min_score     <= 8'd50;
      cfg_q.model_side    <= 11'd192;
      cfg_q.width_scale   <= 24'd65536;
      cfg_q.height_scale  <= 24'd65536;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        dobd_pkg::CFG_NUM_CLASSES:   cfg_q.num_classes   <= cfg_data_i[6:0];
        dobd_pkg::CFG_ZERO_OFFSET:   cfg_q.zero_offset   <= $signed(cfg_data_i[7:0]);
        dobd_pkg::CFG_DEQUANT_SCALE: cfg_q.dequant_scale <= cfg_data_i;
        dobd_pkg::CFG_MIN_SCORE:     cfg_q.min_score     <= cfg_data_i[7:0];
        dobd_pkg::CFG_MODEL_SIDE:    cfg_q.model_side    <= cfg_data_i[10:0];
        dobd_pkg::CFG_WIDTH_SCALE:   cfg_q.width_scale   <= cfg_data_i;
        dobd_pkg::CFG_HEIGHT_SCALE:  cfg_q.height_scale  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Input handshake: stall only when no queue entry is free.
  assign in_ready_o = !q_full;
  assign accept     = in_valid_i && in_ready_o;

  dobd_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg_q),
    .accept_i        (accept),
    .element_value_i (element_value_i),
    .rec_o           (push_rec),
    .push_o          (push)
  );

  dobd_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_rec),
    .pop_i       (pop),
    .full_o      (q_full),
    .valid_o     (q_valid),
    .data_o      (head_rec)
  );

  dobd_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .rec_valid_i   (q_valid),
    .rec_i         (head_rec),
    .rec_pop_o     (pop),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .box_x_o       (box_x_o),
    .box_y_o       (box_y_o),
    .box_w_o       (box_w_o),
    .box_h_o       (box_h_o),
    .score_o       (score_o),
    .class_index_o (class_index_o)
  );

endmodule

`default_nettype wire

>>> sv/dobd_checker.sv
// Port-level checks for the detector output box decoder, bound to the top level.
// Depends on dobd_pkg and detector_output_box_decode_top.
`timescale 1ns / 1ps
`default_nettype none

module dobd_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid_i,
  input wire logic        in_ready_o,
  input wire logic        out_valid_o,
  input wire logic        out_ready_i,
  input wire logic [15:0] box_x_o,
  input wire logic [15:0] box_y_o,
  input wire logic [15:0] box_w_o,
  input wire logic [15:0] box_h_o,
  input wire logic [7:0]  score_o,
  input wire logic [6:0]  class_index_o
);

  // A stalled result request stays up.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result request dropped while stalled");

  // A stalled result request keeps its payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=>
      $stable(box_x_o) && $stable(box_y_o) && $stable(box_w_o) &&
      $stable(box_h_o) && $stable(score_o) && $stable(class_index_o))
    else $error("result payload changed while stalled");

  // The class index always names a supported class.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> class_index_o < 7'(dobd_pkg::MAX_CLASSES))
    else $error("class index out of range");

  // Coming out of reset the input is ready and no result is pending.
  assert property (@(posedge clk_i)
    $rose(rst_ni) |-> in_ready_o && !out_valid_o)
    else $error("reset did not clear the queue or the output");

endmodule

bind detector_output_box_decode_top dobd_checker u_dobd_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_ready_o    (in_ready_o),
  .out_valid_o   (out_valid_o),
  .out_ready_i   (out_ready_i),
  .box_x_o       (box_x_o),
  .box_y_o       (box_y_o),
  .box_w_o       (box_w_o),
  .box_h_o       (box_h_o),
  .score_o       (score_o),
  .class_index_o (class_index_o)
);

`default_nettype wire

>>> verif/detector_output_box_decode_top_test.sv
// Self-checking testbench for the detector output box decoder top level.
// Streams int8 records through the element request channel and checks every box against
// a local decode model; depends on dobd_pkg and detector_output_box_decode_top.
`timescale 1ns / 1ps

module detector_output_box_decode_top_test;

  // Cycles the back end may still be busy after the last box has come out.
  localparam int unsigned SETTLE_CYCLES  = 40;
  // Cycles without any accepted request before the run is declared hung.
  localparam int unsigned WATCHDOG_LIMIT = 4000;
  localparam int unsigned PHASE_ITEMS    = 180;

  typedef struct packed {
    logic [15:0] box_x;
    logic [15:0] box_y;
    logic [15:0] box_w;
    logic [15:0] box_h;
    logic [7:0]  score;
    logic [6:0]  class_index;
  } box_result_t;

  logic              clk_i           = 1'b0;
  logic              rst_ni          = 1'b0;
  logic              cfg_we_i        = 1'b0;
  logic [2:0]        cfg_index_i     = '0;
  logic [23:0]       cfg_data_i      = '0;
  logic              in_valid_i      = 1'b0;
  logic signed [7:0] element_value_i = '0;
  logic              out_ready_i     = 1'b0;
  logic              in_ready_o;
  logic              out_valid_o;
  logic [15:0]       box_x_o;
  logic [15:0]       box_y_o;
  logic [15:0]       box_w_o;
  logic [15:0]       box_h_o;
  logic [7:0]        score_o;
  logic [6:0]        class_index_o;

  // Elements waiting to be sent and boxes waiting to come out.
  logic [7:0]  element_backlog[$];
  box_result_t expected_boxes[$];

  // Local copy of the decoder registers and record state.
  dobd_pkg::cfg_t    cfg_shadow;
  logic [6:0]        elem_pos;
  logic signed [7:0] best_value;
  logic [6:0]        best_class;
  logic signed [7:0] raw_x, raw_y, raw_w, raw_h;
  box_result_t       next_box;

  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned error_count    = 0;
  int unsigned results_seen   = 0;
  int unsigned quiet_cycles   = 0;
  logic        progress       = 1'b0;

  detector_output_box_decode_top dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .element_value_i(element_value_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .box_x_o        (box_x_o),
    .box_y_o        (box_y_o),
    .box_w_o        (box_w_o),
    .box_h_o        (box_h_o),
    .score_o        (score_o),
    .class_index_o  (class_index_o)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  function automatic dobd_pkg::cfg_t make_settings(input logic [6:0] nc,
                                                   input logic [7:0] zp,
                                                   input logic [23:0] scale,
                                                   input logic [7:0] thr,
                                                   input logic [10:0] side,
                                                   input logic [23:0] ws,
                                                   input logic [23:0] hs);
    dobd_pkg::cfg_t s;
    s.num_classes   = nc;
    s.zero_offset   = zp;
    s.dequant_scale = scale;
    s.min_score     = thr;
    s.model_side    = side;
    s.width_scale   = ws;
    s.height_scale  = hs;
    return s;
  endfunction

  // A class count of zero acts as one, anything above the maximum as the maximum.
  function automatic int unsigned effective_classes(input logic [6:0] nc);
    if (nc == 0) return 1;
    if (nc > dobd_pkg::MAX_CLASSES) return dobd_pkg::MAX_CLASSES;
    return nc;
  endfunction

  function automatic logic [23:0] pick_image_scale();
    case ($urandom_range(3))
      0: return 24'd0;
      1: return 24'd65536;
      2: return 24'($urandom_range(24'h3FFFF));
      default: return 24'($urandom);
    endcase
  endfunction

  function automatic dobd_pkg::cfg_t random_settings(input int unsigned p);
    logic [6:0]  nc;
    logic [7:0]  zp;
    logic [23:0] scale;
    logic [7:0]  thr;
    logic [10:0] side;
    case (p % 8)
      2: nc = 7'($urandom_range(127, 81));
      5: nc = 7'd0;
      6: nc = 7'($urandom_range(80, 11));
      default: nc = 7'($urandom_range(10, 1));
    endcase
    // Mostly negative zero points so that many records clear the threshold.
    zp = ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(236, 128));
    case ($urandom_range(3))
      0: scale = 24'($urandom_range(6553, 1));
      1: scale = 24'($urandom_range(131072, 6554));
      2: scale = $urandom_range(1) ? 24'd6553 : 24'd6554;
      default: scale = 24'($urandom);
    endcase
    thr = ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(80));
    case ($urandom_range(3))
      0, 1: side = 11'($urandom_range(32, 1) * 32);
      2: side = 11'($urandom);
      default: side = 11'd1024;
    endcase
    return make_settings(nc, zp, scale, thr, side, pick_image_scale(), pick_image_scale());
  endfunction

  // Box value: dequantize, rescale in percent mode, clip to the model side,
  // then apply the image scale and saturate.
  function automatic logic [15:0] scaled_box(input logic signed [7:0] raw, input bit pct,
                                             input logic [23:0] img_scale);
    longint v, ceiling, r;
    v = (longint'(raw) - longint'($signed(cfg_shadow.zero_offset)))
        * longint'(cfg_shadow.dequant_scale);
    ceiling = longint'(cfg_shadow.model_side) * 65536;
    if (pct) v = v * longint'(cfg_shadow.model_side);
    if (v < 0) v = 0;
    if (v > ceiling) v = ceiling;
    r = (v * longint'(img_scale)) >>> 32;
    return (r > 65535) ? 16'hFFFF : r[15:0];
  endfunction

  // Advance the record state by one element and queue the box it produces.
  task automatic decode_element(input logic signed [7:0] e);
    int unsigned classes, t;
    bit          pct;
    longint      sc, rs;
    box_result_t res;
    classes = effective_classes(cfg_shadow.num_classes);
    if (elem_pos < dobd_pkg::POS_CLASS) begin
      case (elem_pos)
        dobd_pkg::POS_X: raw_x = e;
        dobd_pkg::POS_Y: raw_y = e;
        dobd_pkg::POS_W: raw_w = e;
        default: raw_h = e;
      endcase
      elem_pos = elem_pos + 7'd1;
    end else begin
      t = elem_pos - dobd_pkg::POS_CLASS;
      if (t == 0) begin
        best_value = -8'sd128;
        best_class = '0;
      end
      // Strict compare keeps the first class holding the maximum.
      if (e > best_value) begin
        best_value = e;
        best_class = 7'(t);
      end
      if (t + 1 < classes) begin
        elem_pos = elem_pos + 7'd1;
      end else begin
        elem_pos = dobd_pkg::POS_X;
        pct = cfg_shadow.dequant_scale < dobd_pkg::SCALE_PCT_LIMIT;
        sc = (longint'(best_value) - longint'($signed(cfg_shadow.zero_offset)))
             * longint'(cfg_shadow.dequant_scale);
        if (pct) sc = sc * longint'(dobd_pkg::PCT_FACTOR);
        if (sc > longint'(cfg_shadow.min_score) * 65536) begin
          rs = (sc + 32768) >>> 16;
          res.box_x       = scaled_box(raw_x, pct, cfg_shadow.width_scale);
          res.box_y       = scaled_box(raw_y, pct, cfg_shadow.height_scale);
          res.box_w       = scaled_box(raw_w, pct, cfg_shadow.width_scale);
          res.box_h       = scaled_box(raw_h, pct, cfg_shadow.height_scale);
          res.score       = (rs > 255) ? 8'hFF : rs[7:0];
          res.class_index = best_class;
          expected_boxes.push_back(res);
        end
      end
    end
  endtask

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("%0t: box decode mismatch on %s: got %0d, want %0d", $time, what, got, want);
    error_count++;
  endtask

  task automatic write_register(input logic [2:0] index, input logic [23:0] data);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= index;
    cfg_data_i  <= data;
  endtask

  task automatic finish_writes();
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic load_settings(input dobd_pkg::cfg_t s);
    write_register(dobd_pkg::CFG_NUM_CLASSES,   {17'd0, s.num_classes});
    write_register(dobd_pkg::CFG_ZERO_OFFSET,   {16'd0, s.zero_offset});
    write_register(dobd_pkg::CFG_DEQUANT_SCALE, s.dequant_scale);
    write_register(dobd_pkg::CFG_MIN_SCORE,     {16'd0, s.min_score});
    write_register(dobd_pkg::CFG_MODEL_SIDE,    {13'd0, s.model_side});
    write_register(dobd_pkg::CFG_WIDTH_SCALE,   s.width_scale);
    write_register(dobd_pkg::CFG_HEIGHT_SCALE,  s.height_scale);
    finish_writes();
  endtask

  // Queue up to eight elements given most significant byte first.
  task automatic queue_bytes(input logic [63:0] bytes, input int unsigned count);
    for (int unsigned i = 0; i < count; i++) begin
      element_backlog.push_back(bytes[8 * (count - 1 - i) +: 8]);
    end
  endtask

  task automatic queue_random_record(input int unsigned classes, output int unsigned pushed);
    bit         ties;
    logic [7:0] tie_value;
    ties      = ($urandom_range(3) == 0);
    tie_value = 8'($urandom);
    repeat (4) element_backlog.push_back(8'($urandom));
    repeat (classes) begin
      element_backlog.push_back((ties && $urandom_range(1)) ? tie_value : 8'($urandom));
    end
    pushed = classes + 4;
  endtask

  // Wait until every element is taken and every box has come out, then let the
  // back end finish any record that makes no box.
  task automatic wait_until_idle();
    do @(negedge clk_i);
    while (element_backlog.size() != 0 || in_valid_i || expected_boxes.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  // Element driver: holds a request until it is taken, idles at random.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i      <= 1'b0;
      element_value_i <= '0;
    end else if (!in_valid_i || in_ready_o) begin
      if (element_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_valid_i      <= 1'b1;
        element_value_i <= element_backlog.pop_front();
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Box receiver: stalls at random.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Monitor: checks box requests, feeds the decode model and tracks register writes.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_shadow = make_settings(7'd80, 8'd0, 24'd256, 8'd50, 11'd192, 24'd65536, 24'd65536);
      elem_pos   = dobd_pkg::POS_X;
      best_value = -8'sd128;
      best_class = '0;
      raw_x      = '0;
      raw_y      = '0;
      raw_w      = '0;
      raw_h      = '0;
      progress   = 1'b0;
    end else begin
      progress = cfg_we_i || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i);
      if (out_valid_o && out_ready_i) begin
        if (expected_boxes.size() == 0) begin
          report_mismatch("box request with none outstanding", 1, 0);
        end else begin
          next_box = expected_boxes.pop_front();
          results_seen++;
          if (box_x_o !== next_box.box_x) report_mismatch("box_x", box_x_o, next_box.box_x);
          if (box_y_o !== next_box.box_y) report_mismatch("box_y", box_y_o, next_box.box_y);
          if (box_w_o !== next_box.box_w) report_mismatch("box_w", box_w_o, next_box.box_w);
          if (box_h_o !== next_box.box_h) report_mismatch("box_h", box_h_o, next_box.box_h);
          if (score_o !== next_box.score) report_mismatch("score", score_o, next_box.score);
          if (class_index_o !== next_box.class_index) begin
            report_mismatch("class_index", class_index_o, next_box.class_index);
          end
        end
      end
      if (in_valid_i && in_ready_o) decode_element(element_value_i);
      if (cfg_we_i) begin
        case (cfg_index_i)
          dobd_pkg::CFG_NUM_CLASSES:   cfg_shadow.num_classes   = cfg_data_i[6:0];
          dobd_pkg::CFG_ZERO_OFFSET:   cfg_shadow.zero_offset   = cfg_data_i[7:0];
          dobd_pkg::CFG_DEQUANT_SCALE: cfg_shadow.dequant_scale = cfg_data_i;
          dobd_pkg::CFG_MIN_SCORE:     cfg_shadow.min_score     = cfg_data_i[7:0];
          dobd_pkg::CFG_MODEL_SIDE:    cfg_shadow.model_side    = cfg_data_i[10:0];
          dobd_pkg::CFG_WIDTH_SCALE:   cfg_shadow.width_scale   = cfg_data_i;
          dobd_pkg::CFG_HEIGHT_SCALE:  cfg_shadow.height_scale  = cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  // Watchdog: only counts while work is outstanding and nothing moves.
  always @(negedge clk_i) begin
    if (progress || (element_backlog.size() == 0 && !in_valid_i && expected_boxes.size() == 0))
    begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("detector_output_box_decode_top_test: FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Stimulus sequence.
  initial begin
    dobd_pkg::cfg_t s;
    int unsigned    queued, part, classes;
    bit             held;
    held = 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // One record under the reset configuration.
    queue_random_record(dobd_pkg::MAX_CLASSES, part);
    wait_until_idle();

    // Extremes: a saturated score and box, then a score exactly at a zero threshold.
    load_settings(make_settings(7'd1, 8'h80, 24'd65536, 8'd0, 11'd1024, 24'hFFFFFF,
                                24'hFFFFFF));
    queue_bytes({8'd127, 8'h80, 8'd0, 8'd64, 8'd127}, 5);
    queue_bytes({8'hFF, 8'd1, 8'h80, 8'd127, 8'h80}, 5);
    wait_until_idle();

    // Zero class count with zero model side, then zero scale.
    load_settings(make_settings(7'd0, 8'd0, 24'd65536, 8'd0, 11'd0, 24'd65536, 24'd65536));
    queue_bytes({8'd100, 8'd50, 8'hF6, 8'd20, 8'd60}, 5);
    wait_until_idle();
    write_register(dobd_pkg::CFG_DEQUANT_SCALE, 24'd0);
    finish_writes();
    queue_bytes({8'h80, 8'd127, 8'd1, 8'hFF, 8'd127}, 5);
    wait_until_idle();

    // Percent mode with tied scores, and the class count lowered mid-record.
    load_settings(make_settings(7'd6, 8'h80, 24'd6553, 8'd255, 11'd32, 24'd1, 24'h800000));
    queue_bytes({8'h80, 8'd127, 8'd5, 8'hFB, 8'd10, 8'd10, 8'h80}, 7);
    wait_until_idle();
    write_register(dobd_pkg::CFG_NUM_CLASSES, 24'd2);
    finish_writes();
    queue_bytes(64'd10, 1);
    wait_until_idle();

    // Random records over several settings and idle patterns.
    for (int unsigned p = 0; p < 8 || (results_seen < 48 && p < 14); p++) begin
      send_idle_pct  = (p % 4 == 1) ? 72 : (p % 4 == 3) ? 29 : 0;
      recv_stall_pct = (p % 4 == 2) ? 72 : (p % 4 == 3) ? 29 : 0;
      s = random_settings(p);
      load_settings(s);
      classes = effective_classes(s.num_classes);
      queued  = 0;
      while (queued < PHASE_ITEMS) begin
        queue_random_record(classes, part);
        queued += part;
        // Once, hold the sender until every box has come out.
        if (p == 1 && !held && queued >= PHASE_ITEMS / 2) begin
          held = 1'b1;
          wait_until_idle();
        end
      end
      wait_until_idle();
    end

    if (error_count == 0) begin
      $display("detector_output_box_decode_top_test: PASS");
    end else begin
      $display("detector_output_box_decode_top_test: FAIL");
    end
    $finish;
  end

endmodule
